FILE: design/pidw_pkg.sv
// Shared types, codes and saturation helpers for the weighted anti-windup PID block.
// No dependencies; imported by pidw_alu, pid_weighted_antiwindup_top, pidw_checker and tb_top.
package pidw_pkg;

  localparam int          FRAC_BITS  = 16;
  localparam logic [16:0] WEIGHT_ONE = 17'h10000;
  localparam logic [31:0] DT_MIN     = 32'd4294;  // about one microsecond in Q0.32
  localparam logic [6:0]  MUL_STEPS  = 7'd32;

  // sequencer steps
  localparam logic [2:0] STEP_BLW = 3'd0;  // weight * error
  localparam logic [2:0] STEP_BLM = 3'd1;  // (1 - weight) * measured
  localparam logic [2:0] STEP_P   = 3'd2;
  localparam logic [2:0] STEP_INC = 3'd3;
  localparam logic [2:0] STEP_I   = 3'd4;
  localparam logic [2:0] STEP_D   = 3'd5;
  localparam logic [2:0] STEP_DIV = 3'd6;

  localparam logic [1:0] CLAMP_NONE  = 2'd0;
  localparam logic [1:0] CLAMP_UPPER = 2'd1;
  localparam logic [1:0] CLAMP_LOWER = 2'd2;

  localparam logic [2:0] REG_PROP   = 3'd0;
  localparam logic [2:0] REG_INTEG  = 3'd1;
  localparam logic [2:0] REG_DERIV  = 3'd2;
  localparam logic [2:0] REG_BLEND  = 3'd3;
  localparam logic [2:0] REG_PERIOD = 3'd4;
  localparam logic [2:0] REG_UPPER  = 3'd5;
  localparam logic [2:0] REG_LOWER  = 3'd6;

  typedef struct packed {
    logic start;
    logic is_div;
  } alu_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } alu_stat_t;

  function automatic logic [63:0] sat128(input logic [127:0] v);
    logic [63:0] r;
    if ((&v[127:63]) || !(|v[127:63])) begin
      r = v[63:0];
    end else begin
      r = v[127] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end
    return r;
  endfunction

  function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    logic [63:0] r;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      r = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      r = s[63:0];
    end
    return r;
  endfunction

endpackage

FILE: design/pidw_alu.sv
// Shared iterative unit: MSB-first shift-add multiplier (signed x unsigned, one bit a cycle)
// and restoring divider (one quotient bit a cycle). Depends on pidw_pkg.
module pidw_alu import pidw_pkg::*; #(
  parameter int DIV_BITS = 81
) (
  input  logic          clk,
  input  logic          rst_n,
  input  alu_cmd_t      cmd,
  input  logic [63:0]   mcand,
  input  logic [31:0]   mplr,
  input  logic [31:0]   divisor,
  input  logic [127:0]  dividend,
  output alu_stat_t     stat,
  output logic [127:0]  result
);

  logic [127:0] acc_r;
  logic [63:0]  mcand_r;
  logic [31:0]  mplr_r;
  logic [31:0]  dvsr_r;
  logic [31:0]  rem_r;
  logic [6:0]   cnt_r;
  logic         busy_r;
  logic         done_r;
  logic         div_r;

  logic [127:0] mul_nxt;
  logic [32:0]  trial;
  logic         ge;
  logic [32:0]  diff;
  logic [31:0]  rem_nxt;

  assign mul_nxt = {acc_r[126:0], 1'b0} +
                   (mplr_r[31] ? {{64{mcand_r[63]}}, mcand_r} : 128'd0);
  assign trial   = {rem_r, acc_r[DIV_BITS-1]};
  assign ge      = trial >= {1'b0, dvsr_r};
  assign diff    = trial - {1'b0, dvsr_r};
  assign rem_nxt = ge ? diff[31:0] : trial[31:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (cmd.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == 7'd1) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      div_r   <= cmd.is_div;
      mcand_r <= mcand;
      mplr_r  <= mplr;
      dvsr_r  <= divisor;
      rem_r   <= 32'd0;
      acc_r   <= cmd.is_div ? dividend : 128'd0;
      cnt_r   <= cmd.is_div ? 7'(DIV_BITS) : MUL_STEPS;
    end else if (busy_r) begin
      cnt_r <= cnt_r - 7'd1;
      if (div_r) begin
        rem_r <= rem_nxt;
        acc_r <= {acc_r[126:0], ge};
      end else begin
        acc_r  <= mul_nxt;
        mplr_r <= {mplr_r[30:0], 1'b0};
      end
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign result    = acc_r;

endmodule

FILE: design/pid_weighted_antiwindup_top.sv
// Top level of the weighted-setpoint PID controller with clamping anti-windup.
// Depends on pidw_pkg and pidw_alu.

// One sample is taken at a time. Every product goes through one shared shift-add unit at one
// multiplier bit a cycle, and the derivative divide through the same unit at one quotient
// bit a cycle. With a period of one microsecond or less the derivative steps are skipped.
// The next sample is taken once the result is in the output register, even if it still waits.
// A configuration write to indices 0 to 6 clears the integral and the stored previous error.
module pid_weighted_antiwindup_top import pidw_pkg::*; #(
  parameter int SIGNAL_WIDTH = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [SIGNAL_WIDTH-1:0] in_target,
  input  logic [SIGNAL_WIDTH-1:0] in_measured,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [SIGNAL_WIDTH-1:0] out_drive,
  output logic [1:0]              out_clamp_hit,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [2:0]              cfg_index,
  input  logic [((SIGNAL_WIDTH > 32) ? SIGNAL_WIDTH : 32)-1:0] cfg_data
);

  localparam int EW    = SIGNAL_WIDTH + 1;
  localparam int DFW   = SIGNAL_WIDTH + 2;
  localparam int NUM_W = SIGNAL_WIDTH + 49;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_RUN   = 2'd1;
  localparam logic [1:0] S_SUM   = 2'd2;
  localparam logic [1:0] S_CLAMP = 2'd3;

  logic [1:0]  state_r, state_nxt;
  logic [2:0]  step_r, step_nxt;

  logic [31:0] kp_r, ki_r, kd_r, dt_r;
  logic [16:0] blend_r;
  logic [SIGNAL_WIDTH-1:0] hi_r, lo_r;
  logic [63:0] accum_r;
  logic [EW-1:0] last_r;

  logic [EW-1:0] err_r;
  logic [SIGNAL_WIDTH-1:0] meas_r;
  logic signed [127:0] base_r;
  logic        neg_r, dneg_r;
  logic [63:0] prior_r, p_r, i_r, d_r, sum_r;

  logic        out_valid_r;
  logic [SIGNAL_WIDTH-1:0] out_drive_r;
  logic [1:0]  out_clamp_r;

  alu_cmd_t    alu_cmd;
  alu_stat_t   alu_stat;
  logic [63:0] alu_mcand;
  logic [31:0] alu_mplr;
  logic [127:0] alu_dividend;
  logic [127:0] alu_res;

  logic        accept, cfg_wr, out_free;
  logic [EW-1:0] err_in;
  logic [DFW-1:0] diff;
  logic [16:0] w_eff;
  logic [31:0] kp_mag, ki_mag, kd_mag;
  logic signed [127:0] prod_s, dmag, q_ext, dq;
  logic [63:0] blend, acc_new, s_fin, hi64, lo64;

  assign accept   = in_valid && !in_stall;
  assign cfg_wr   = cfg_valid && cfg_ready;
  assign out_free = !out_valid_r || !out_stall;

  assign err_in = {in_target[SIGNAL_WIDTH-1], in_target} -
                  {in_measured[SIGNAL_WIDTH-1], in_measured};
  assign diff   = {err_r[EW-1], err_r} - {last_r[EW-1], last_r};
  assign w_eff  = (blend_r > WEIGHT_ONE) ? WEIGHT_ONE : blend_r;
  assign kp_mag = kp_r[31] ? (32'd0 - kp_r) : kp_r;
  assign ki_mag = ki_r[31] ? (32'd0 - ki_r) : ki_r;
  assign kd_mag = kd_r[31] ? (32'd0 - kd_r) : kd_r;

  assign prod_s  = neg_r ? (base_r - $signed(alu_res)) : (base_r + $signed(alu_res));
  assign blend   = prod_s[79:16];
  assign acc_new = sat_add64(accum_r, sat128(prod_s >>> FRAC_BITS));
  assign dmag    = prod_s[127] ? -prod_s : prod_s;
  assign q_ext   = {{(128-NUM_W){1'b0}}, alu_res[NUM_W-1:0]};
  assign dq      = dneg_r ? -q_ext : q_ext;

  assign s_fin = sat_add64(sum_r, d_r);
  assign hi64  = {{(64-SIGNAL_WIDTH){hi_r[SIGNAL_WIDTH-1]}}, hi_r};
  assign lo64  = {{(64-SIGNAL_WIDTH){lo_r[SIGNAL_WIDTH-1]}}, lo_r};

  pidw_alu #(
    .DIV_BITS (NUM_W)
  ) u_alu (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (alu_cmd),
    .mcand    (alu_mcand),
    .mplr     (alu_mplr),
    .divisor  (dt_r),
    .dividend (alu_dividend),
    .stat     (alu_stat),
    .result   (alu_res)
  );

  // sequencer: each finished step but the last issues the next operation to the shared unit
  always_comb begin
    alu_cmd      = '0;
    alu_mcand    = 64'd0;
    alu_mplr     = 32'd0;
    alu_dividend = 128'd0;
    state_nxt    = state_r;
    step_nxt     = step_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          alu_cmd.start = 1'b1;
          alu_mcand     = {{(64-EW){err_in[EW-1]}}, err_in};
          alu_mplr      = {15'd0, w_eff};
          step_nxt      = STEP_BLW;
          state_nxt     = S_RUN;
        end
      end
      S_RUN: begin
        if (alu_stat.done) begin
          unique case (step_r)
            STEP_BLW: begin
              alu_cmd.start = 1'b1;
              alu_mcand     = {{(64-SIGNAL_WIDTH){meas_r[SIGNAL_WIDTH-1]}}, meas_r};
              alu_mplr      = {15'd0, WEIGHT_ONE - w_eff};
              step_nxt      = STEP_BLM;
            end
            STEP_BLM: begin
              alu_cmd.start = 1'b1;
              alu_mcand     = blend;
              alu_mplr      = kp_mag;
              step_nxt      = STEP_P;
            end
            STEP_P: begin
              alu_cmd.start = 1'b1;
              alu_mcand     = {{(64-EW){err_r[EW-1]}}, err_r};
              alu_mplr      = dt_r;
              step_nxt      = STEP_INC;
            end
            STEP_INC: begin
              alu_cmd.start = 1'b1;
              alu_mcand     = acc_new;
              alu_mplr      = ki_mag;
              step_nxt      = STEP_I;
            end
            STEP_I: begin
              if (dt_r > DT_MIN) begin
                alu_cmd.start = 1'b1;
                alu_mcand     = {{(64-DFW){diff[DFW-1]}}, diff};
                alu_mplr      = kd_mag;
                step_nxt      = STEP_D;
              end else begin
                state_nxt = S_SUM;
              end
            end
            STEP_D: begin
              alu_cmd.start  = 1'b1;
              alu_cmd.is_div = 1'b1;
              alu_dividend   = dmag << FRAC_BITS;
              step_nxt       = STEP_DIV;
            end
            STEP_DIV: state_nxt = S_SUM;
            default:  state_nxt = S_IDLE;
          endcase
        end
      end
      S_SUM:   state_nxt = S_CLAMP;
      S_CLAMP: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= STEP_BLW;
      out_valid_r <= 1'b0;
      kp_r        <= 32'd0;
      ki_r        <= 32'd0;
      kd_r        <= 32'd0;
      blend_r     <= WEIGHT_ONE;
      dt_r        <= 32'd0;
      hi_r        <= {1'b0, {(SIGNAL_WIDTH-1){1'b1}}};
      lo_r        <= {1'b1, {(SIGNAL_WIDTH-1){1'b0}}};
      accum_r     <= 64'd0;
      last_r      <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      if (state_r == S_RUN && alu_stat.done && step_r == STEP_INC) begin
        accum_r <= acc_new;
      end
      if (state_r == S_CLAMP && out_free) begin
        out_valid_r <= 1'b1;
        last_r      <= err_r;
        // anti-windup: drop this sample's integral step when the output is clamped
        if ($signed(s_fin) > $signed(hi64) || $signed(s_fin) < $signed(lo64)) begin
          accum_r <= prior_r;
        end
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr) begin
        unique case (cfg_index)
          REG_PROP:   kp_r    <= cfg_data[31:0];
          REG_INTEG:  ki_r    <= cfg_data[31:0];
          REG_DERIV:  kd_r    <= cfg_data[31:0];
          REG_BLEND:  blend_r <= cfg_data[16:0];
          REG_PERIOD: dt_r    <= cfg_data[31:0];
          REG_UPPER:  hi_r    <= cfg_data[SIGNAL_WIDTH-1:0];
          REG_LOWER:  lo_r    <= cfg_data[SIGNAL_WIDTH-1:0];
          default: ;
        endcase
        if (cfg_index <= REG_LOWER) begin
          accum_r <= 64'd0;
          last_r  <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      err_r  <= err_in;
      meas_r <= in_measured;
      base_r <= '0;
      neg_r  <= 1'b0;
    end
    if (state_r == S_RUN && alu_stat.done) begin
      unique case (step_r)
        STEP_BLW: begin
          base_r <= prod_s;
          neg_r  <= 1'b1;
        end
        STEP_BLM: begin
          base_r <= '0;
          neg_r  <= kp_r[31];
        end
        STEP_P: begin
          p_r   <= sat128(prod_s >>> FRAC_BITS);
          neg_r <= 1'b0;
        end
        STEP_INC: begin
          prior_r <= accum_r;
          neg_r   <= ki_r[31];
        end
        STEP_I: begin
          i_r   <= sat128(prod_s >>> 32);
          neg_r <= kd_r[31];
          d_r   <= 64'd0;
        end
        STEP_D:   dneg_r <= prod_s[127];
        STEP_DIV: d_r    <= sat128(dq);
        default: ;
      endcase
    end
    if (state_r == S_SUM) begin
      sum_r <= sat_add64(p_r, i_r);
    end
    if (state_r == S_CLAMP && out_free) begin
      priority if ($signed(s_fin) > $signed(hi64)) begin
        out_drive_r <= hi_r;
        out_clamp_r <= CLAMP_UPPER;
      end else if ($signed(s_fin) < $signed(lo64)) begin
        out_drive_r <= lo_r;
        out_clamp_r <= CLAMP_LOWER;
      end else begin
        out_drive_r <= s_fin[SIGNAL_WIDTH-1:0];
        out_clamp_r <= CLAMP_NONE;
      end
    end
  end

  assign in_stall      = (state_r != S_IDLE);
  assign cfg_ready     = (state_r == S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_drive     = out_drive_r;
  assign out_clamp_hit = out_clamp_r;

  a_alu_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> !alu_stat.busy)
    else $error("shared unit busy while taking a new sample");

  a_done_run: assert property (@(posedge clk) disable iff (!rst_n)
    alu_stat.done |-> state_r == S_RUN)
    else $error("shared unit finished outside the run state");

  a_upper_val: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_clamp_hit == CLAMP_UPPER) |-> out_drive == hi_r)
    else $error("upper clamp reported with a drive other than the limit");

  a_lower_val: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_clamp_hit == CLAMP_LOWER) |-> out_drive == lo_r)
    else $error("lower clamp reported with a drive other than the limit");

endmodule

FILE: verif/pidw_checker.sv
// Checker for the weighted anti-windup PID block: tracks register writes, predicts each
// sample's drive and clamp flag, and compares them with the result channel.
// Depends on pidw_pkg for clamp and register codes, WEIGHT_ONE and DT_MIN.
module pidw_checker import pidw_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [31:0] in_target,
  input  logic [31:0] in_measured,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] out_drive,
  input  logic [1:0]  out_clamp_hit,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          fail_count,
  output int          drives_pending,
  output int          drives_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic signed [127:0] S64_MAX = {65'd0, {63{1'b1}}};
  localparam logic signed [127:0] S64_MIN = {{65{1'b1}}, 63'd0};

  typedef struct {
    logic [31:0] drive;
    logic [1:0]  hit;
  } drive_exp_t;

  drive_exp_t drive_q[$];

  logic [31:0] kp_r, ki_r, kd_r, period_r, upper_r, lower_r;
  logic [16:0] blend_r;
  logic signed [63:0] integ_acc, prev_err;

  function automatic logic signed [127:0] clip64(input logic signed [127:0] v);
    if (v > S64_MAX) return S64_MAX;
    if (v < S64_MIN) return S64_MIN;
    return v;
  endfunction

  function automatic drive_exp_t pid_sample(input logic [31:0] tgt_u, input logic [31:0] meas_u);
    logic signed [127:0] tg, ms, er, wv, kp, ki, kd, dtv, bl, pt, it, dt_term;
    logic signed [127:0] acc_new, num, sum, hi_lim, lo_lim;
    drive_exp_t r;
    tg = $signed(tgt_u);
    ms = $signed(meas_u);
    er = tg - ms;
    wv = (blend_r > WEIGHT_ONE) ? {111'd0, WEIGHT_ONE} : {111'd0, blend_r};
    kp = $signed(kp_r);
    ki = $signed(ki_r);
    kd = $signed(kd_r);
    dtv = {96'd0, period_r};
    hi_lim = $signed(upper_r);
    lo_lim = $signed(lower_r);
    bl = clip64((wv * er + (wv - 128'sd65536) * ms) >>> 16);
    pt = clip64((kp * bl) >>> 16);
    acc_new = clip64(128'(integ_acc) + clip64((er * dtv) >>> 16));
    it = clip64((ki * acc_new) >>> 32);
    dt_term = 0;
    if (period_r > DT_MIN) begin
      num = kd * (er - 128'(prev_err));
      dt_term = clip64((num <<< 16) / dtv);  // signed divide truncates toward zero
    end
    prev_err = er[63:0];
    sum = clip64(clip64(pt + it) + dt_term);
    r.hit = CLAMP_NONE;
    r.drive = sum[31:0];
    if (sum > hi_lim) begin
      r.drive = upper_r;
      r.hit = CLAMP_UPPER;
    end else if (sum < lo_lim) begin
      r.drive = lower_r;
      r.hit = CLAMP_LOWER;
    end
    if (r.hit == CLAMP_NONE) integ_acc = acc_new[63:0];
    return r;
  endfunction

  always @(posedge clk) begin
    drive_exp_t e;
    if (!rst_n) begin
      kp_r = 0; ki_r = 0; kd_r = 0; period_r = 0;
      blend_r = WEIGHT_ONE;
      upper_r = 32'h7FFF_FFFF;
      lower_r = 32'h8000_0000;
      integ_acc = 0; prev_err = 0;
      drive_q.delete();
      fail_count = 0;
      drives_seen = 0;
      drives_pending = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PROP:   kp_r = cfg_data;
          REG_INTEG:  ki_r = cfg_data;
          REG_DERIV:  kd_r = cfg_data;
          REG_BLEND:  blend_r = cfg_data[16:0];
          REG_PERIOD: period_r = cfg_data;
          REG_UPPER:  upper_r = cfg_data;
          REG_LOWER:  lower_r = cfg_data;
          default: ;
        endcase
        if (cfg_index <= REG_LOWER) begin
          integ_acc = 0;
          prev_err = 0;
        end
      end
      if (in_valid && !in_stall) drive_q.push_back(pid_sample(in_target, in_measured));
      if (out_valid && !out_stall) begin
        drives_seen++;
        if (drive_q.size() == 0) begin
          $display("%0t: unexpected result drive=%h hit=%0d", $time, out_drive, out_clamp_hit);
          fail_count++;
        end else begin
          e = drive_q.pop_front();
          if (e.drive !== out_drive || e.hit !== out_clamp_hit) begin
            $display("%0t: mismatch expected drive=%h hit=%0d actual drive=%h hit=%0d",
                     $time, e.drive, e.hit, out_drive, out_clamp_hit);
            fail_count++;
          end
        end
      end
      drives_pending = drive_q.size();
    end
  end
endmodule

FILE: verif/tb_top.sv
// Testbench top for pid_weighted_antiwindup_top: drives samples and register writes
// under varying idle patterns. Depends on pidw_pkg, the block and pidw_checker.
module tb_top import pidw_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE = 400;
  localparam longint LIMIT = 6000000;
  localparam logic [2:0] REG_UNUSED = 3'd7;

  logic clk = 0, rst_n = 0;
  logic in_valid = 0, out_stall = 0, cfg_valid = 0;
  logic [31:0] in_target = 0, in_measured = 0, cfg_data = 0;
  logic [2:0] cfg_index = 0;
  logic in_stall, out_valid, cfg_ready;
  logic [31:0] out_drive;
  logic [1:0] out_clamp_hit;
  int fail_count, drives_pending, drives_seen;
  int tx_idle_pct = 17, rx_idle_pct = 70;
  logic hold_req = 0;
  int hold_left = 0;
  longint cycles = 0;
  int n_samples = 0, n_writes = 0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  pid_weighted_antiwindup_top #(.SIGNAL_WIDTH(32)) u_top (.*);

  pidw_checker u_chk (.*);

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // receiver stall, with a long hold-off on request
  always @(negedge clk) begin
    if (hold_req) hold_left = 1500;
    if (hold_left > 0) begin
      hold_left--;
      out_stall = 1;
    end else begin
      out_stall = ($urandom_range(99) < rx_idle_pct);
    end
  end

  task automatic send_sample(input logic [31:0] t, input logic [31:0] m);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid = 0;
      @(negedge clk);
    end
    in_valid = 1;
    in_target = t;
    in_measured = m;
    do @(posedge clk); while (in_stall);
    n_samples++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 0;
    wait (drives_pending == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] d);
    @(negedge clk);
    cfg_valid = 1;
    cfg_index = idx;
    cfg_data = d;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 0;
    n_writes++;
  endtask

  function automatic logic [31:0] pick_gain();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 0;
      3: return $urandom;
      default: return $signed($urandom_range(262144)) - 131072;
    endcase
  endfunction

  function automatic logic [31:0] pick_signal();
    case ($urandom_range(9))
      0: return $urandom;
      1: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return $signed($urandom_range(1 << 22)) - (1 << 21);
    endcase
  endfunction

  task automatic random_setup();
    logic [31:0] a, b;
    write_reg(REG_PROP, pick_gain());
    write_reg(REG_INTEG, pick_gain());
    write_reg(REG_DERIV, pick_gain());
    case ($urandom_range(4))
      0: write_reg(REG_BLEND, 0);
      1: write_reg(REG_BLEND, WEIGHT_ONE);
      2: write_reg(REG_BLEND, $urandom_range(131071, 65537));
      default: write_reg(REG_BLEND, $urandom_range(65536));
    endcase
    case ($urandom_range(5))
      0: write_reg(REG_PERIOD, 0);
      1: write_reg(REG_PERIOD, $urandom_range(4294));
      2: write_reg(REG_PERIOD, 4295);
      3: write_reg(REG_PERIOD, 32'hFFFF_FFFF);
      default: write_reg(REG_PERIOD, $urandom);
    endcase
    a = pick_signal();
    b = pick_signal();
    // limits crossed now and then
    if ($urandom_range(5) == 0 || $signed(a) < $signed(b)) begin
      write_reg(REG_UPPER, b);
      write_reg(REG_LOWER, a);
    end else begin
      write_reg(REG_UPPER, a);
      write_reg(REG_LOWER, b);
    end
  endtask

  initial begin
    int k;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1;
    repeat (SETTLE) @(posedge clk);

    // directed: reset settings, then extremes under set gains, crossed limits and full-scale gains
    send_sample(32'h7FFF_FFFF, 32'h8000_0000);
    send_sample(32'h8000_0000, 32'h7FFF_FFFF);
    send_sample(0, 0);
    drain();
    write_reg(REG_PROP, 32'h0001_0000);
    write_reg(REG_INTEG, 32'h0002_0000);
    write_reg(REG_DERIV, 32'h0000_1000);
    write_reg(REG_BLEND, 17'h1FFFF);
    write_reg(REG_PERIOD, 32'd4295);
    write_reg(REG_UPPER, 32'h0010_0000);
    write_reg(REG_LOWER, 32'hFFF0_0000);
    write_reg(REG_UNUSED, 32'hDEAD_BEEF);
    send_sample(32'h7FFF_FFFF, 32'h8000_0000);
    send_sample(32'h8000_0000, 32'h7FFF_FFFF);
    send_sample(32'h0000_8000, 0);
    send_sample(0, 32'h0000_8000);
    drain();
    write_reg(REG_BLEND, 0);
    write_reg(REG_PERIOD, 32'd4294);
    write_reg(REG_UPPER, 32'hFFF0_0000);   // crossed limits
    write_reg(REG_LOWER, 32'h0010_0000);
    send_sample(32'h0100_0000, 0);
    send_sample(0, 0);
    send_sample(32'hFF00_0000, 32'h0000_0001);
    drain();
    write_reg(REG_PROP, 32'h8000_0000);
    write_reg(REG_INTEG, 32'h7FFF_FFFF);
    write_reg(REG_DERIV, 32'h8000_0000);
    write_reg(REG_PERIOD, 32'hFFFF_FFFF);
    write_reg(REG_UPPER, 32'h7FFF_FFFF);
    write_reg(REG_LOWER, 32'h8000_0000);
    for (k = 0; k < 6; k++) send_sample($urandom, $urandom);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      random_setup();
      for (k = 0; k < 250; k++) begin
        if (k == 0) begin
          tx_idle_pct = (ph < 2) ? 17 : (ph < 4) ? 70 : 0;
          rx_idle_pct = (ph < 2) ? 70 : (ph < 4) ? 17 : 0;
        end
        if (ph == 4 && k == 20) begin
          @(posedge clk) hold_req = 1;
          @(posedge clk) hold_req = 0;
        end
        if (ph == 5 && k == 125) begin
          // sender pause until every result is back
          @(negedge clk) in_valid = 0;
          wait (drives_pending == 0);
        end
        send_sample(pick_signal(), pick_signal());
      end
      drain();
    end

    $display("Covered %0d samples, %0d register writes, %0d results checked over 6 phases",
             n_samples, n_writes, drives_seen);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

FILE: files.f
design/pidw_pkg.sv
design/pidw_alu.sv
design/pid_weighted_antiwindup_top.sv
verif/pidw_checker.sv
verif/tb_top.sv
